// ===== design/irt_pkg.sv =====
// Shared types, constants and status codes for the runtime interpolation table.
package irt_pkg;

    localparam int MachinesDefault = 16;
    localparam int PointsDefault   = 16;

    localparam logic       FUNC_WRITE = 1'b0;
    localparam logic       FUNC_QUERY = 1'b1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_INTERP = 3'd1;
    localparam logic [2:0] ST_NOTAB  = 3'd2;
    localparam logic [2:0] ST_RANGE  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic        func;
        logic [3:0]  machine_index;
        logic [31:0] units;
        logic [47:0] runtime_in;
        logic [16:0] completed;
    } irt_in_t;

    typedef struct packed {
        logic [47:0] runtime_out;
        logic [2:0]  status;
    } irt_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture input word, clear index
        logic rd;         // issue memory read at index
        logic cmp;        // compare read key, advance index
        logic idx_to_cnt; // save insert slot, move index to point count
        logic shift_rd;   // read entry index-1 for shifting
        logic shift_wr;   // write held entry at index, step down
        logic ins_wr;     // write new point at index
        logic upd_wr;     // overwrite value at index
        logic cnt_inc;    // bump the machine's point count
        logic rd_lo;      // read entry index-1 (lower neighbor)
        logic lat_lo;     // latch lower neighbor
        logic lat_hi;     // latch upper neighbor (last read)
        logic mul_start;  // start product |v1-v0|*(u-k0), lower half
        logic mul_hi;     // add upper half of the product
        logic div_start;  // start division
        logic div_step;   // one quotient bit
        logic fin_interp; // form interpolated result
        logic fin_exact;  // take the matched value
        logic scl_mul;    // scale by (1 - completed)
        logic set_out;    // set result with given status
        logic [2:0] out_status;
        logic out_zero;
    } irt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic func;
        logic bad_machine;
        logic empty;
        logic full;
        logic idx_at_count; // index reached point count
        logic idx_at_pos;   // index reached the insert slot
        logic key_lt;       // read key < units
        logic key_eq;       // read key == units
        logic idx_zero;     // index == 0
        logic div_done;
    } irt_sts_t;

endpackage

// ===== design/irt_datapath.sv =====
// Datapath: table memories, point counts, search index, interpolation arithmetic.
module irt_datapath
    import irt_pkg::*;
#(
    parameter int MACHINES = MachinesDefault,
    parameter int POINTS   = PointsDefault
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  irt_in_t  in_word,
    input  irt_cmd_t cmd,
    output irt_sts_t sts,
    output irt_out_t out_word
);
    localparam int MW    = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int PW    = $clog2(POINTS);
    localparam int CW    = $clog2(POINTS + 1);
    // Each machine owns a power-of-two slice so the address is {machine, index}.
    localparam int DEPTH = MACHINES * (2 ** PW);
    localparam int AW    = $clog2(DEPTH);

    logic [31:0] key_mem [DEPTH];
    logic [47:0] val_mem [DEPTH];
    logic [CW-1:0] count_reg [MACHINES];

    irt_in_t     req_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] pos_reg;
    logic [MW-1:0] mach_reg;
    logic        bad_reg;
    logic [31:0] rkey_reg;
    logic [47:0] rval_reg;
    logic [31:0] k0_reg, k1_reg;
    logic [47:0] v0_reg, v1_reg;
    logic [79:0] prod_reg;
    logic [79:0] quo_reg;
    logic [32:0] rem_reg;
    logic [6:0]  step_reg;
    logic [47:0] res_reg;
    logic [63:0] scl_reg;
    logic        scl_pend_reg;
    irt_out_t    out_reg;

    logic [AW-1:0] addr_cur, addr_prev;
    logic [PW-1:0] idx_lo, idx_m1;
    logic [31:0]   dkey, tkey;
    logic [47:0]   dval;
    logic          neg;
    logic [32:0]   rem_sh;
    logic [16:0]   cclip;
    logic [16:0]   keep;

    assign idx_lo = idx_reg[PW-1:0];
    assign idx_m1 = idx_lo - 1'b1;
    if (MACHINES > 1) begin : g_addr
        assign addr_cur  = AW'({mach_reg, idx_lo});
        assign addr_prev = AW'({mach_reg, idx_m1});
    end else begin : g_addr1
        assign addr_cur  = AW'(idx_lo);
        assign addr_prev = AW'(idx_m1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rkey_reg <= key_mem[addr_cur];
            rval_reg <= val_mem[addr_cur];
        end
        else if (cmd.shift_rd || cmd.rd_lo)
        begin
            rkey_reg <= key_mem[addr_prev];
            rval_reg <= val_mem[addr_prev];
        end
        if (cmd.shift_wr)
        begin
            key_mem[addr_cur] <= rkey_reg;
            val_mem[addr_cur] <= rval_reg;
        end
        else if (cmd.ins_wr)
        begin
            key_mem[addr_cur] <= req_reg.units;
            val_mem[addr_cur] <= req_reg.runtime_in;
        end
        else if (cmd.upd_wr)
        begin
            val_mem[addr_cur] <= req_reg.runtime_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MACHINES; i++)
                count_reg[i] <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_reg[mach_reg] <= n_reg + 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
            idx_next = '0;
        else if (cmd.cmp && rkey_reg < req_reg.units)
            idx_next = idx_reg + 1'b1;
        else if (cmd.idx_to_cnt)
            idx_next = n_reg;
        else if (cmd.shift_wr)
            idx_next = idx_reg - 1'b1;
    end

    assign dkey   = k1_reg - k0_reg;
    assign tkey   = req_reg.units - k0_reg;
    assign neg    = v1_reg < v0_reg;
    assign dval   = neg ? (v0_reg - v1_reg) : (v1_reg - v0_reg);
    assign rem_sh = {rem_reg[31:0], quo_reg[79]};
    assign cclip  = (req_reg.completed > 17'd65536) ? 17'd65536 : req_reg.completed;
    assign keep   = 17'd65536 - cclip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            n_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
                n_reg <= (32'(in_word.machine_index) >= MACHINES) ? '0
                       : count_reg[MW'(in_word.machine_index)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= in_word;
            mach_reg <= MW'(in_word.machine_index);
            bad_reg  <= 32'(in_word.machine_index) >= MACHINES;
        end
        if (cmd.idx_to_cnt)
            pos_reg <= idx_reg;
        if (cmd.lat_hi)
        begin
            k1_reg <= rkey_reg;
            v1_reg <= rval_reg;
        end
        if (cmd.lat_lo)
        begin
            k0_reg <= rkey_reg;
            v0_reg <= rval_reg;
        end
        // The 48 by 32 product is built from two 24-bit halves, lower half first.
        if (cmd.mul_start)
            prod_reg <= {24'd0, 56'(dval[23:0]) * 56'(tkey)};
        else if (cmd.mul_hi)
            prod_reg <= prod_reg + {56'(dval[47:24]) * 56'(tkey), 24'd0};
        // Restoring division of the 80-bit product by the key gap, one bit a cycle.
        if (cmd.div_start)
        begin
            quo_reg  <= prod_reg;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, dkey})
            begin
                rem_reg <= rem_sh - {1'b0, dkey};
                quo_reg <= {quo_reg[78:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[78:0], 1'b0};
            end
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.fin_interp)
            res_reg <= neg ? (v0_reg - quo_reg[47:0] - 48'(rem_reg != '0))
                           : (v0_reg + quo_reg[47:0]);
        else if (cmd.fin_exact)
            res_reg <= rval_reg;
        if (cmd.scl_mul)
            scl_reg <= res_reg * keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scl_pend_reg <= 1'b0;
        else
            scl_pend_reg <= cmd.scl_mul;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_out)
        begin
            out_reg.status      <= cmd.out_status;
            out_reg.runtime_out <= '0;
        end
        else if (scl_pend_reg)
        begin
            out_reg.runtime_out <= scl_reg[63:16];
        end
    end

    assign out_word = out_reg;

    always_comb
    begin
        sts.func         = req_reg.func;
        sts.bad_machine  = bad_reg;
        sts.empty        = n_reg == '0;
        sts.full         = 32'(n_reg) >= POINTS;
        sts.idx_at_count = idx_reg == n_reg;
        sts.idx_at_pos   = idx_reg == pos_reg;
        sts.key_lt       = rkey_reg < req_reg.units;
        sts.key_eq       = rkey_reg == req_reg.units;
        sts.idx_zero     = idx_reg == '0;
        sts.div_done     = step_reg == 7'd80;
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.load |-> idx_reg <= n_reg)
        else $error("search index beyond point count");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> 32'(n_reg) < POINTS)
        else $error("insert into a full table");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> step_reg < 7'd80)
        else $error("division ran past its length");

endmodule

// ===== design/irt_ctrl.sv =====
// Controller: sequences search, insert, interpolation and result handoff.
module irt_ctrl
    import irt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  irt_sts_t sts,
    output irt_cmd_t cmd
);
    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_CHK   = 17'b00000000000000010,
        S_RD    = 17'b00000000000000100,
        S_CMP   = 17'b00000000000001000,
        S_DEC   = 17'b00000000000010000,
        S_SRD   = 17'b00000000000100000,
        S_SWR   = 17'b00000000001000000,
        S_LO    = 17'b00000000010000000,
        S_LOL   = 17'b00000000100000000,
        S_MUL   = 17'b00000001000000000,
        S_MUL2  = 17'b00000010000000000,
        S_DIVS  = 17'b00000100000000000,
        S_DIV   = 17'b00001000000000000,
        S_FIN   = 17'b00010000000000000,
        S_SCL   = 17'b00100000000000000,
        S_SCLW  = 17'b01000000000000000,
        S_OUT   = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   hit_reg, hit_next;

    // Output word is presented in S_OUT; it waits there until taken.
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        state_next = state_reg;
        hit_next   = hit_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                hit_next = 1'b0;
                if (sts.bad_machine || (sts.func == FUNC_QUERY && sts.empty))
                begin
                    cmd.set_out    = 1'b1;
                    cmd.out_status = ST_NOTAB;
                    state_next     = S_OUT;
                end
                else
                    state_next = S_RD;
            end
            S_RD:
            begin
                if (sts.idx_at_count)
                    state_next = S_DEC;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (sts.key_lt)
                    state_next = S_RD;
                else
                begin
                    hit_next   = sts.key_eq;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.func == FUNC_WRITE)
                begin
                    if (hit_reg)
                    begin
                        cmd.upd_wr     = 1'b1;
                        cmd.set_out    = 1'b1;
                        cmd.out_status = ST_OK;
                        state_next     = S_OUT;
                    end
                    else if (sts.full)
                    begin
                        cmd.set_out    = 1'b1;
                        cmd.out_status = ST_FULL;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        // Remember the insert slot and start shifting from the top.
                        cmd.cnt_inc    = 1'b1;
                        cmd.idx_to_cnt = 1'b1;
                        state_next     = S_SRD;
                    end
                end
                else if (hit_reg)
                begin
                    cmd.fin_exact  = 1'b1;
                    cmd.set_out    = 1'b1;
                    cmd.out_status = ST_OK;
                    state_next     = S_SCL;
                end
                else if (sts.idx_zero || sts.idx_at_count)
                begin
                    cmd.set_out    = 1'b1;
                    cmd.out_status = ST_RANGE;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.lat_hi = 1'b1;
                    state_next = S_LO;
                end
            end
            // Insertion shifts from the top: the index is moved up to the count first.
            S_SRD:
            begin
                if (sts.idx_at_pos)
                begin
                    cmd.ins_wr     = 1'b1;
                    cmd.set_out    = 1'b1;
                    cmd.out_status = ST_OK;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SWR;
                end
            end
            S_SWR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SRD;
            end
            S_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = S_LOL;
            end
            S_LOL:
            begin
                cmd.lat_lo = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_FIN;
                else
                    cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.fin_interp = 1'b1;
                cmd.set_out    = 1'b1;
                cmd.out_status = ST_INTERP;
                state_next     = S_SCL;
            end
            S_SCL:
            begin
                cmd.scl_mul = 1'b1;
                state_next  = S_SCLW;
            end
            // The scaled runtime lands in the output register during this cycle.
            S_SCLW:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("accepting while a word is pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

endmodule

// ===== design/interp_runtime_table.sv =====
// Top level of the per-machine runtime interpolation table.
// A word first has its machine and table checked; a bad machine or an empty-table query is
// answered at once, and other words search the points below their key. An insert then shifts
// every point above the insert slot; an exact-hit query is scaled, and an interpolated query
// runs a two-half product, an 80-step divider and the scaling.
// The block takes one word at a time; the next is accepted only after the result is handed off.
// Reset clears the state machine and all point counts; table memories are not cleared.
module interp_runtime_table
    import irt_pkg::*;
#(
    parameter int MACHINES = MachinesDefault,
    parameter int POINTS   = PointsDefault
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  irt_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output irt_out_t out_data
);
    irt_cmd_t cmd;
    irt_sts_t sts;

    irt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    irt_datapath #(
        .MACHINES (MACHINES),
        .POINTS   (POINTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (out_data)
    );

endmodule

// ===== test/irt_checker.sv =====
// Checker that predicts table results from accepted words and compares them.
`timescale 1ns / 100ps
module irt_checker
    import irt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  irt_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  irt_out_t out_data,
    output int       fail_count,
    output int       pending,
    output int       results_seen,
    output int       interp_seen
);

    localparam int NMACH = MachinesDefault;
    localparam int NPTS  = PointsDefault;

    logic [31:0] tab_key   [NMACH][NPTS];
    logic [47:0] tab_value [NMACH][NPTS];
    int          tab_count [NMACH];
    irt_out_t    expected_q[$];

    // floor(a * t / d) with exact wide arithmetic; also reports a nonzero remainder.
    function automatic logic [47:0] scaled_share(logic [47:0] a, logic [31:0] t,
                                                 logic [32:0] d, output logic inexact);
        logic [79:0] prod;
        prod = a * t;
        inexact = (prod % d) != 0;
        return 48'(prod / d);
    endfunction

    function automatic irt_out_t predict_runtime(irt_in_t w);
        irt_out_t    r;
        int          m;
        int          n;
        int          pos;
        logic [47:0] v0;
        logic [47:0] v1;
        logic [47:0] q;
        logic        inexact;
        logic [47:0] res;
        logic [16:0] c;
        logic [64:0] sc;
        r.runtime_out = '0;
        r.status = ST_OK;
        m = w.machine_index;
        if (m >= NMACH) begin
            r.status = ST_NOTAB;
            return r;
        end
        n = tab_count[m];
        pos = 0;
        while (pos < n && tab_key[m][pos] < w.units) pos++;
        if (w.func == FUNC_WRITE) begin
            if (pos < n && tab_key[m][pos] == w.units) begin
                tab_value[m][pos] = w.runtime_in;
            end else if (n >= NPTS) begin
                r.status = ST_FULL;
            end else begin
                for (int i = n; i > pos; i--) begin
                    tab_key[m][i]   = tab_key[m][i-1];
                    tab_value[m][i] = tab_value[m][i-1];
                end
                tab_key[m][pos]   = w.units;
                tab_value[m][pos] = w.runtime_in;
                tab_count[m]      = n + 1;
            end
            return r;
        end
        if (n == 0) begin
            r.status = ST_NOTAB;
            return r;
        end
        if (pos < n && tab_key[m][pos] == w.units) begin
            res = tab_value[m][pos];
        end else if (pos == 0 || pos >= n) begin
            r.status = ST_RANGE;
            return r;
        end else begin
            v0 = tab_value[m][pos-1];
            v1 = tab_value[m][pos];
            if (v1 >= v0) begin
                q = scaled_share(v1 - v0, w.units - tab_key[m][pos-1],
                                 33'(tab_key[m][pos]) - tab_key[m][pos-1], inexact);
                res = v0 + q;
            end else begin
                q = scaled_share(v0 - v1, w.units - tab_key[m][pos-1],
                                 33'(tab_key[m][pos]) - tab_key[m][pos-1], inexact);
                res = v0 - q - inexact;
            end
            r.status = ST_INTERP;
        end
        c = (w.completed > 17'd65536) ? 17'd65536 : w.completed;
        sc = res * (65'd65536 - c);
        r.runtime_out = 48'(sc >> 16);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        irt_out_t e;
        if (!rst_n) begin
            for (int i = 0; i < NMACH; i++) tab_count[i] = 0;
            expected_q.delete();
            pending = 0;
            fail_count   <= 0;
            results_seen <= 0;
            interp_seen  <= 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: result word with nothing expected: %h", out_data);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.status == ST_INTERP) interp_seen <= interp_seen + 1;
                    if (e.runtime_out !== out_data.runtime_out
                            || e.status !== out_data.status) begin
                        if (fail_count < 10)
                            $display("ERROR: expected runtime %h status %0d, got %h status %0d",
                                     e.runtime_out, e.status,
                                     out_data.runtime_out, out_data.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_runtime(in_data));
            pending = expected_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives table writes and queries into the block and gives the verdict.
`timescale 1ns / 100ps
module tb;
    import irt_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    irt_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    irt_out_t out_data;
    int       fail_count;
    int       pending;
    int       results_seen;
    int       interp_seen;
    logic     long_hold;

    // Keys per machine used by the random part so that queries hit and miss often.
    logic [31:0] key_pool [16][8];

    interp_runtime_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    irt_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .interp_seen(interp_seen)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("interp_runtime_table regression: fail");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked.
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold) begin
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ready = 1'b0;
                repeat (gap_len()) @(negedge clk);
                out_ready = 1'b1;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    task automatic send_word(logic f, logic [3:0] m, logic [31:0] u, logic [47:0] rt,
                             logic [16:0] c);
        irt_in_t w;
        w.func = f;
        w.machine_index = m;
        w.units = u;
        w.runtime_in = rt;
        w.completed = c;
        in_data  = w;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap_len()) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [16:0] pick_completed();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [47:0] pick_runtime();
        case ($urandom_range(0, 4))
            0: return 48'hFFFF_FFFF_FFFF;
            1: return 48'd0;
            default: return 48'({$urandom(), $urandom()});
        endcase
    endfunction

    initial begin
        logic [3:0]  m;
        logic [31:0] u;
        int          k;
        in_valid     = 1'b0;
        in_data      = '0;
        long_hold    = 1'b0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, writes at the key extremes, hits, interpolation between falling values.
        send_word(FUNC_QUERY, 4'd3, 32'd100, 48'd0, 17'd0);
        send_word(FUNC_WRITE, 4'd3, 32'd1000, 48'h0001_0000_0000, 17'd0);
        send_word(FUNC_WRITE, 4'd3, 32'd0, 48'hFFFF_FFFF_FFFF, 17'd0);
        send_word(FUNC_WRITE, 4'd3, 32'hFFFF_FFFF, 48'd0, 17'd0);
        send_word(FUNC_QUERY, 4'd3, 32'd1000, 48'd0, 17'd0);
        send_word(FUNC_QUERY, 4'd3, 32'd500, 48'd0, 17'd0);
        send_word(FUNC_QUERY, 4'd3, 32'h8000_0000, 48'd0, 17'd32768);
        send_word(FUNC_QUERY, 4'd3, 32'd7, 48'd0, 17'd65536);
        send_word(FUNC_QUERY, 4'd3, 32'd7, 48'd0, 17'h1FFFF);
        send_word(FUNC_WRITE, 4'd3, 32'd1000, 48'h1234_5678_9ABC, 17'd0);
        send_word(FUNC_QUERY, 4'd3, 32'd1000, 48'd0, 17'd1);
        send_word(FUNC_WRITE, 4'd15, 32'd10, 48'd5, 17'd0);
        send_word(FUNC_QUERY, 4'd15, 32'd9, 48'd0, 17'd0);
        send_word(FUNC_QUERY, 4'd15, 32'd11, 48'd0, 17'd0);
        // Fill machine 0 past capacity to reach the full-table error.
        for (int i = 0; i < 17; i++)
            send_word(FUNC_WRITE, 4'd0, 32'(i * 37 + 5), pick_runtime(), 17'd0);
        send_word(FUNC_WRITE, 4'd0, 32'd5, 48'd77, 17'd0);
        send_word(FUNC_QUERY, 4'd0, 32'd20, 48'd0, 17'd0);

        // Sender pause until everything is back.
        wait_drained();

        // Long receiver hold-off while words keep coming.
        long_hold = 1'b1;
        for (int i = 0; i < 6; i++)
            send_word(FUNC_WRITE, 4'd7, $urandom(), pick_runtime(), 17'd0);

        for (int mi = 0; mi < 16; mi++)
            for (int j = 0; j < 8; j++)
                key_pool[mi][j] = ($urandom_range(0, 3) == 0) ? $urandom()
                                                               : 32'($urandom_range(0, 5000));

        for (int n = 0; n < 950; n++) begin
            m = 4'($urandom_range(0, 15));
            k = $urandom_range(0, 7);
            u = key_pool[m][k];
            case ($urandom_range(0, 9))
                0, 1, 2: send_word(FUNC_WRITE, m, u, pick_runtime(), 17'($urandom()));
                3: send_word(FUNC_WRITE, m, $urandom(), pick_runtime(), 17'($urandom()));
                4: send_word(FUNC_QUERY, m, $urandom(), 48'({$urandom(), $urandom()}),
                             pick_completed());
                5: send_word(FUNC_QUERY, m, u, 48'd0, pick_completed());
                default: send_word(FUNC_QUERY, m,
                                   u + 32'($urandom_range(0, 2500)) - 32'd1250,
                                   48'({$urandom(), $urandom()}), pick_completed());
            endcase
        end

        wait_drained();
        repeat (200) @(negedge clk);
        $display("Covered %0d result words, %0d of them interpolated, with random stalls",
                 results_seen, interp_seen);
        $display("on both channels, a long output hold-off and full-table writes.");
        if (fail_count == 0)
            $display("interp_runtime_table regression: pass");
        else
            $display("interp_runtime_table regression: fail");
        $finish;
    end

endmodule
